// ===== design/assert_macros.svh =====
// assertion macros shared by the scanner rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/lts_pkg.sv =====
// types, character codes and helpers for the lisp token scanner
// no dependencies
package lts_pkg;

   typedef enum logic [2:0] {
      MODE_INIT = 3'd0,
      MODE_NUM  = 3'd1,
      MODE_NEG  = 3'd2,
      MODE_FLT  = 3'd3,
      MODE_WORD = 3'd4,
      MODE_STR  = 3'd5,
      MODE_ESC  = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      KIND_OPEN    = 3'd0,
      KIND_CLOSE   = 3'd1,
      KIND_WORD    = 3'd2,
      KIND_STRING  = 3'd3,
      KIND_NUMBER  = 3'd4,
      KIND_UNKNOWN = 3'd5,
      KIND_ERROR   = 3'd6,
      KIND_END     = 3'd7
   } kind_type;

   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_QUOTE     = 8'd34;
   localparam logic [7:0] CH_OPEN      = 8'd40;
   localparam logic [7:0] CH_CLOSE     = 8'd41;
   localparam logic [7:0] CH_PLUS      = 8'd43;
   localparam logic [7:0] CH_MINUS     = 8'd45;
   localparam logic [7:0] CH_DOT       = 8'd46;
   localparam logic [7:0] CH_ZERO      = 8'd48;
   localparam logic [7:0] CH_NINE      = 8'd57;
   localparam logic [7:0] CH_UPPER_A   = 8'd65;
   localparam logic [7:0] CH_UPPER_Z   = 8'd90;
   localparam logic [7:0] CH_BACKSLASH = 8'd92;
   localparam logic [7:0] CH_UNDERLINE = 8'd95;
   localparam logic [7:0] CH_LOWER_A   = 8'd97;
   localparam logic [7:0] CH_LOWER_Z   = 8'd122;

   // flag bits of a pending token
   localparam int FLAG_FLOAT    = 0;
   localparam int FLAG_NEGATIVE = 1;

   // result queue depth, power of two, at least two
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      kind_type    kind;
      logic        is_float;
      logic        is_negative;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic        last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_wordlike(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             (c == CH_UNDERLINE) || (c == CH_MINUS) || (c == CH_PLUS);
   endfunction

endpackage

// ===== design/lts_scan_core.sv =====
// next-state and token logic for one character or end-of-input mark
// depends on lts_pkg
module lts_scan_core import lts_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic [7:0]               character,
   input  logic                     end_of_input,
   input  mode_type                 mode,
   input  logic [POSITION_BITS-1:0] position,
   input  logic [POSITION_BITS-1:0] token_start,
   input  logic [POSITION_BITS-1:0] token_end,
   input  kind_type                 pending_kind,
   input  logic [1:0]               pending_flags,
   output mode_type                 mode_in,
   output logic [POSITION_BITS-1:0] position_in,
   output logic [POSITION_BITS-1:0] token_start_in,
   output logic [POSITION_BITS-1:0] token_end_in,
   output kind_type                 pending_kind_in,
   output logic [1:0]               pending_flags_in,
   output token_type                token0,
   output token_type                token1,
   output logic [1:0]               token_count
);

   logic [POSITION_BITS-1:0] idx;
   logic [POSITION_BITS-1:0] nxt;

   // what the initial mode does with this character
   logic     init_start;
   logic     init_is_str;
   mode_type init_mode;
   kind_type init_kind;
   logic     init_emit;
   kind_type init_emit_kind;

   assign idx = position;
   assign nxt = position + 1'b1;

   always_comb begin
      init_start     = 1'b0;
      init_is_str    = 1'b0;
      init_mode      = MODE_INIT;
      init_kind      = KIND_UNKNOWN;
      init_emit      = 1'b0;
      init_emit_kind = KIND_ERROR;
      if (character == CH_MINUS) begin
         init_start = 1'b1;
         init_mode  = MODE_NEG;
         init_kind  = KIND_WORD;
      end else if (is_digit(character)) begin
         init_start = 1'b1;
         init_mode  = MODE_NUM;
         init_kind  = KIND_NUMBER;
      end else if (is_wordlike(character)) begin
         init_start = 1'b1;
         init_mode  = MODE_WORD;
         init_kind  = KIND_WORD;
      end else if (character == CH_OPEN) begin
         init_emit      = 1'b1;
         init_emit_kind = KIND_OPEN;
      end else if (character == CH_CLOSE) begin
         init_emit      = 1'b1;
         init_emit_kind = KIND_CLOSE;
      end else if (character == CH_QUOTE) begin
         init_start  = 1'b1;
         init_is_str = 1'b1;
         init_mode   = MODE_STR;
         init_kind   = KIND_STRING;
      end else if (character != CH_SPACE) begin
         init_emit      = 1'b1;
         init_emit_kind = KIND_ERROR;
      end
   end

   always_comb begin
      logic      again;
      logic      run_init;
      token_type pend_tok;
      token_type end_tok;
      token_type emit_tok;

      again    = 1'b0;
      run_init = 1'b0;

      pend_tok             = '0;
      pend_tok.kind        = pending_kind;
      pend_tok.is_float    = pending_flags[FLAG_FLOAT];
      pend_tok.is_negative = pending_flags[FLAG_NEGATIVE];
      pend_tok.start_pos   = 16'(token_start);
      pend_tok.end_pos     = 16'(token_end);

      end_tok           = '0;
      end_tok.kind      = KIND_END;
      end_tok.start_pos = 16'(position);
      end_tok.end_pos   = 16'(position);

      emit_tok           = '0;
      emit_tok.kind      = init_emit_kind;
      emit_tok.start_pos = 16'(idx);
      emit_tok.end_pos   = 16'(nxt);

      mode_in          = mode;
      position_in      = position;
      token_start_in   = token_start;
      token_end_in     = token_end;
      pending_kind_in  = pending_kind;
      pending_flags_in = pending_flags;
      token0           = '0;
      token1           = '0;
      token_count      = 2'd0;

      if (end_of_input) begin
         if (mode inside {[MODE_NUM:MODE_ESC]}) begin
            token0      = pend_tok;
            token1      = end_tok;
            token_count = 2'd2;
         end else begin
            token0      = end_tok;
            token_count = 2'd1;
         end
         mode_in          = MODE_INIT;
         position_in      = '0;
         token_start_in   = '0;
         token_end_in     = '0;
         pending_kind_in  = KIND_UNKNOWN;
         pending_flags_in = '0;
      end else begin
         position_in = nxt;
         case (mode)
            MODE_NUM, MODE_FLT: begin
               if (is_digit(character)) begin
                  token_end_in = nxt;
               end else if ((character == CH_DOT) && (mode == MODE_NUM)) begin
                  mode_in                      = MODE_FLT;
                  pending_flags_in[FLAG_FLOAT] = 1'b1;
                  token_end_in                 = nxt;
               end else begin
                  again = 1'b1;
               end
            end
            MODE_NEG: begin
               if (is_digit(character)) begin
                  mode_in                         = MODE_NUM;
                  pending_kind_in                 = KIND_NUMBER;
                  pending_flags_in[FLAG_NEGATIVE] = 1'b1;
                  token_end_in                    = nxt;
               end else begin
                  again = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_wordlike(character)) begin
                  token_end_in = nxt;
               end else begin
                  again = 1'b1;
               end
            end
            MODE_STR: begin
               if (character == CH_QUOTE) begin
                  token0             = '0;
                  token0.kind        = KIND_STRING;
                  token0.start_pos   = 16'(token_start);
                  token0.end_pos     = 16'(token_end);
                  token_count        = 2'd1;
                  mode_in            = MODE_INIT;
               end else begin
                  if (character == CH_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end
                  token_end_in = nxt;
               end
            end
            MODE_ESC: begin
               token_end_in = nxt;
               mode_in      = MODE_STR;
            end
            default: begin
               run_init = 1'b1;
            end
         endcase

         if (again) begin
            token0      = pend_tok;
            token_count = 2'd1;
            run_init    = 1'b1;
         end

         if (run_init) begin
            mode_in = MODE_INIT;
            if (init_start) begin
               mode_in          = init_mode;
               pending_kind_in  = init_kind;
               pending_flags_in = '0;
               token_start_in   = init_is_str ? nxt : idx;
               token_end_in     = nxt;
            end
            if (init_emit) begin
               if (token_count == 2'd0) begin
                  token0 = emit_tok;
               end else begin
                  token1 = emit_tok;
               end
               token_count = token_count + 2'd1;
            end
         end
      end

      if (token_count == 2'd1) begin
         token0.last = 1'b1;
      end else if (token_count == 2'd2) begin
         token1.last = 1'b1;
      end
   end

endmodule

// ===== design/lts_rsp_queue.sv =====
// result queue: takes up to two tokens per cycle while room_for_two is high, hands out one per transfer
// depends on lts_pkg and assert_macros.svh
module lts_rsp_queue import lts_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  token_type  push0,
   input  token_type  push1,
   output logic       room_for_two,
   output logic       head_valid,
   input  logic       head_ready,
   output token_type  head
);

   `include "assert_macros.svh"

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   token_type       entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic [PW-1:0]   wr_next;
   logic            pop;

   assign wr_next      = wr_ptr_ff + 1'b1;
   assign pop          = head_valid && head_ready;
   assign head_valid   = (count_ff != '0);
   assign head         = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CW'(DEPTH), "queue over depth")
   `ASSERT_CLK(a_push_room, clock, reset, (push_count != 2'd0) |-> room_for_two, "push without room")
   `ASSERT_NEVER(a_push_count, clock, reset, push_count == 2'd3, "more than two tokens pushed")

endmodule

// ===== design/lisp_token_scanner.sv =====
// lisp token scanner top level: state registers, scan logic and result queue
// depends on lts_pkg, lts_scan_core, lts_rsp_queue and assert_macros.svh
//
// channel   dir  payload
// req_*     in   tdata[7:0] character, tlast end of input
// rsp_*     out  tdata start/end position, tuser kind and flags, tlast last token of item
//
// one input transfer per cycle while the result queue has two free slots
// an item yields zero, one or two tokens; the rsp side drains one token per cycle while rsp_tready is high,
// so a run of two-token items fills the queue and stalls the req side
// tokens enter the registered result queue on the item transfer and reach rsp behind any tokens still queued
// reset is synchronous and clears the scan state and the queue
module lisp_token_scanner import lts_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // end of input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] start_position, [31:16] end_position
   output logic [4:0]  rsp_tuser,   // [2:0] token_kind, [3] is_float, [4] is_negative
   output logic        rsp_tlast    // last token of the item
);

   `include "assert_macros.svh"

   localparam int PB = POSITION_BITS;

   mode_type        mode_ff;
   mode_type        mode_in;
   logic [PB-1:0]   position_ff;
   logic [PB-1:0]   position_in;
   logic [PB-1:0]   token_start_ff;
   logic [PB-1:0]   token_start_in;
   logic [PB-1:0]   token_end_ff;
   logic [PB-1:0]   token_end_in;
   kind_type        pending_kind_ff;
   kind_type        pending_kind_in;
   logic [1:0]      pending_flags_ff;
   logic [1:0]      pending_flags_in;

   token_type       token0;
   token_type       token1;
   logic [1:0]      token_count;
   logic [1:0]      push_count;
   logic            req_xfer;
   logic            room_for_two;
   token_type       head;

   assign req_tready = room_for_two;
   assign req_xfer   = req_tvalid && req_tready;
   assign push_count = req_xfer ? token_count : 2'd0;

   lts_scan_core #(
      .POSITION_BITS(PB)
   ) u_core (
      .character        (req_tdata),
      .end_of_input     (req_tlast),
      .mode             (mode_ff),
      .position         (position_ff),
      .token_start      (token_start_ff),
      .token_end        (token_end_ff),
      .pending_kind     (pending_kind_ff),
      .pending_flags    (pending_flags_ff),
      .mode_in          (mode_in),
      .position_in      (position_in),
      .token_start_in   (token_start_in),
      .token_end_in     (token_end_in),
      .pending_kind_in  (pending_kind_in),
      .pending_flags_in (pending_flags_in),
      .token0           (token0),
      .token1           (token1),
      .token_count      (token_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_INIT;
         position_ff      <= '0;
         token_start_ff   <= '0;
         token_end_ff     <= '0;
         pending_kind_ff  <= KIND_UNKNOWN;
         pending_flags_ff <= '0;
      end else if (req_xfer) begin
         mode_ff          <= mode_in;
         position_ff      <= position_in;
         token_start_ff   <= token_start_in;
         token_end_ff     <= token_end_in;
         pending_kind_ff  <= pending_kind_in;
         pending_flags_ff <= pending_flags_in;
      end
   end

   lts_rsp_queue #(
      .DEPTH(RSP_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (token0),
      .push1        (token1),
      .room_for_two (room_for_two),
      .head_valid   (rsp_tvalid),
      .head_ready   (rsp_tready),
      .head         (head)
   );

   assign rsp_tdata = {head.end_pos, head.start_pos};
   assign rsp_tuser = {head.is_negative, head.is_float, head.kind};
   assign rsp_tlast = head.last;

   `ASSERT_CLK(a_pos_step, clock, reset, (req_xfer && !req_tlast) |=> (position_ff == PB'($past(position_ff) + 1'b1)), "position did not advance by one")
   `ASSERT_CLK(a_eoi_clear, clock, reset, (req_xfer && req_tlast) |=> (position_ff == '0 && mode_ff == MODE_INIT), "end of input did not clear scan state")
   `ASSERT_CLK(a_idle_hold, clock, reset, !req_xfer |=> $stable(position_ff) && $stable(mode_ff), "scan state moved without a transfer")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for lisp_token_scanner: directed and random character streams
// a built-in tokenizer predicts each token, the monitor checks every rsp transfer
// depends on lts_pkg and the scanner rtl
module tb_top;
   import lts_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       eoi;
      logic       hold;
   } char_item_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   lisp_token_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predicted tokenizer state
   mode_type    scan_mode = MODE_INIT;
   kind_type    pend_kind = KIND_UNKNOWN;
   logic [1:0]  pend_flags = 2'b00;
   logic [15:0] scan_pos = 16'd0;
   logic [15:0] tok_start = 16'd0;
   logic [15:0] tok_end = 16'd0;
   int          step_tokens;

   char_item_t  char_queue[$];
   token_type   tok_expected[$];
   char_item_t  next_item;
   token_type   got_tok;
   token_type   want_tok;
   logic        hold_next = 1'b0;
   int          made_items = 0;
   int          chars_sent = 0;
   int          marks_sent = 0;
   int          tokens_checked = 0;
   int          miss_count = 0;
   int          cycle_count = 0;

   logic [7:0]  border_chars [9] = '{8'd33, 8'd44, 8'd46, 8'd47, 8'd58, 8'd64, 8'd91,
                                     8'd96, 8'd123};

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic char_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic char_wordish(logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             c == CH_UNDERLINE || c == CH_MINUS || c == CH_PLUS;
   endfunction

   function automatic void add_token(kind_type k, logic [1:0] f, logic [15:0] s,
                                     logic [15:0] e);
      token_type t;
      t.kind = k;
      t.is_float = f[FLAG_FLOAT];
      t.is_negative = f[FLAG_NEGATIVE];
      t.start_pos = s;
      t.end_pos = e;
      t.last = 1'b0;
      tok_expected.push_back(t);
      step_tokens++;
   endfunction

   function automatic void begin_pending(mode_type m, kind_type k, logic [15:0] s,
                                         logic [15:0] e);
      scan_mode = m;
      pend_kind = k;
      pend_flags = 2'b00;
      tok_start = s;
      tok_end = e;
   endfunction

   function automatic void fresh_char(logic [7:0] c, logic [15:0] idx, logic [15:0] nxt);
      scan_mode = MODE_INIT;
      if (c == CH_MINUS)
         begin_pending(MODE_NEG, KIND_WORD, idx, nxt);
      else if (char_digit(c))
         begin_pending(MODE_NUM, KIND_NUMBER, idx, nxt);
      else if (char_wordish(c))
         begin_pending(MODE_WORD, KIND_WORD, idx, nxt);
      else if (c == CH_OPEN)
         add_token(KIND_OPEN, 2'b00, idx, nxt);
      else if (c == CH_CLOSE)
         add_token(KIND_CLOSE, 2'b00, idx, nxt);
      else if (c == CH_QUOTE)
         begin_pending(MODE_STR, KIND_STRING, nxt, nxt);
      else if (c != CH_SPACE)
         add_token(KIND_ERROR, 2'b00, idx, nxt);
   endfunction

   // advance the predicted tokenizer by one accepted transfer
   function automatic void predict_tokens(logic [7:0] c, logic eoi);
      logic [15:0] idx;
      logic [15:0] nxt;
      logic        again;
      step_tokens = 0;
      again = 1'b0;
      if (eoi) begin
         if (scan_mode != MODE_INIT)
            add_token(pend_kind, pend_flags, tok_start, tok_end);
         add_token(KIND_END, 2'b00, scan_pos, scan_pos);
         scan_mode = MODE_INIT;
         pend_kind = KIND_UNKNOWN;
         pend_flags = 2'b00;
         scan_pos = 16'd0;
         tok_start = 16'd0;
         tok_end = 16'd0;
      end else begin
         idx = scan_pos;
         nxt = idx + 16'd1;
         scan_pos = nxt;
         case (scan_mode)
            MODE_NUM, MODE_FLT: begin
               if (char_digit(c))
                  tok_end = nxt;
               else if (c == CH_DOT && scan_mode == MODE_NUM) begin
                  scan_mode = MODE_FLT;
                  pend_flags[FLAG_FLOAT] = 1'b1;
                  tok_end = nxt;
               end else
                  again = 1'b1;
            end
            MODE_NEG: begin
               if (char_digit(c)) begin
                  scan_mode = MODE_NUM;
                  pend_kind = KIND_NUMBER;
                  pend_flags[FLAG_NEGATIVE] = 1'b1;
                  tok_end = nxt;
               end else
                  again = 1'b1;
            end
            MODE_WORD: begin
               if (char_wordish(c))
                  tok_end = nxt;
               else
                  again = 1'b1;
            end
            MODE_STR: begin
               if (c == CH_QUOTE) begin
                  add_token(KIND_STRING, 2'b00, tok_start, tok_end);
                  scan_mode = MODE_INIT;
               end else begin
                  if (c == CH_BACKSLASH)
                     scan_mode = MODE_ESC;
                  tok_end = nxt;
               end
            end
            MODE_ESC: begin
               tok_end = nxt;
               scan_mode = MODE_STR;
            end
            default: fresh_char(c, idx, nxt);
         endcase
         if (again) begin
            add_token(pend_kind, pend_flags, tok_start, tok_end);
            fresh_char(c, idx, nxt);
         end
      end
      if (step_tokens > 0)
         tok_expected[tok_expected.size() - 1].last = 1'b1;
   endfunction

   function automatic logic idle_roll();
      if (cycle_count >= 1200 && cycle_count < 2000)
         return 1'b0;
      return $urandom_range(99) < 34;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_tokens(req_tdata, req_tlast);
            if (req_tlast)
               marks_sent++;
            else
               chars_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (char_queue.size() > 0 && !(char_queue[0].hold && tok_expected.size() > 0) &&
                !idle_roll()) begin
               next_item = char_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_item.ch;
               req_tlast <= next_item.eoi;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            got_tok.kind = kind_type'(rsp_tuser[2:0]);
            got_tok.is_float = rsp_tuser[3];
            got_tok.is_negative = rsp_tuser[4];
            got_tok.start_pos = rsp_tdata[15:0];
            got_tok.end_pos = rsp_tdata[31:16];
            got_tok.last = rsp_tlast;
            tokens_checked++;
            if (tok_expected.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("unexpected token: kind %0d start %0d end %0d", got_tok.kind,
                           got_tok.start_pos, got_tok.end_pos);
            end else begin
               want_tok = tok_expected.pop_front();
               if (got_tok !== want_tok) begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display({"token mismatch: expected kind %0d flt %0b neg %0b ",
                               "start %0d end %0d last %0b, got kind %0d flt %0b ",
                               "neg %0b start %0d end %0d last %0b"},
                              want_tok.kind, want_tok.is_float, want_tok.is_negative,
                              want_tok.start_pos, want_tok.end_pos, want_tok.last,
                              got_tok.kind, got_tok.is_float, got_tok.is_negative,
                              got_tok.start_pos, got_tok.end_pos, got_tok.last);
               end
            end
         end
         rsp_tready <= !idle_roll();
      end
   end

   task automatic push_char(logic [7:0] c);
      char_queue.push_back('{c, 1'b0, hold_next});
      hold_next = 1'b0;
      made_items++;
   endtask

   task automatic push_eoi();
      char_queue.push_back('{8'($urandom_range(255)), 1'b1, hold_next});
      hold_next = 1'b0;
      made_items++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
   endtask

   // one syntactic form with random content, mostly well formed
   task automatic push_random_form();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) begin
         push_char(CH_OPEN);
      end else if (pick < 22) begin
         push_char(CH_CLOSE);
      end else if (pick < 44) begin
         if ($urandom_range(1))
            push_char(CH_MINUS);
         repeat ($urandom_range(1, 4))
            push_char(CH_ZERO + 8'($urandom_range(9)));
         if ($urandom_range(2) == 0) begin
            push_char(CH_DOT);
            repeat ($urandom_range(3))
               push_char(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(7) == 0)
               push_char(CH_DOT);
         end
      end else if (pick < 62) begin
         repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(5))
               0, 1: push_char(CH_UPPER_A + 8'($urandom_range(25)));
               2, 3: push_char(CH_LOWER_A + 8'($urandom_range(25)));
               4: push_char($urandom_range(1) ? CH_UNDERLINE : CH_PLUS);
               default: push_char(CH_MINUS);
            endcase
         end
      end else if (pick < 77) begin
         push_char(CH_QUOTE);
         repeat ($urandom_range(6)) begin
            if ($urandom_range(3) == 0)
               push_char(CH_BACKSLASH);
            push_char(8'($urandom_range(255)));
         end
         if ($urandom_range(9) != 0)
            push_char(CH_QUOTE);
      end else if (pick < 85) begin
         push_char(CH_MINUS);
      end else if ($urandom_range(1)) begin
         push_char(border_chars[$urandom_range(8)]);
      end else begin
         push_char(8'($urandom_range(255)));
      end
      pick = $urandom_range(29);
      if (pick == 0)
         push_eoi();
      else if (pick < 20)
         push_char(CH_SPACE);
   endtask

   initial begin
      push_text("(- -7.2.)Az+\"\\\"\"");
      push_char(8'hFF);
      push_char(8'h00);
      push_char(CH_NINE);
      push_eoi();
      push_char(CH_MINUS);
      push_eoi();
      push_char(CH_QUOTE);
      push_char(CH_BACKSLASH);
      push_eoi();

      hold_next = 1'b1;
      while (made_items < 900)
         push_random_form();

      // tokens right after an end mark restart from position zero
      hold_next = 1'b1;
      push_eoi();
      push_char(CH_OPEN);
      push_text("12345678");
      push_char(CH_SPACE);
      while (made_items < 1850)
         push_random_form();
      push_eoi();

      while (char_queue.size() > 0 || req_tvalid)
         @(negedge clock);
      while (tok_expected.size() > 0)
         @(negedge clock);
      repeat (16) @(posedge clock);
      $display("covered %0d characters and %0d end marks, %0d tokens checked",
               chars_sent, marks_sent, tokens_checked);
      $display("stream included escapes, flushes at end of input and idle-free stretches");
      if (miss_count == 0 && tok_expected.size() == 0) begin
         $display("** lisp_token_scanner: PASSED **");
      end else begin
         $display("%0d mismatches", miss_count);
         $display("** lisp_token_scanner: FAILED **");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d tokens outstanding", tok_expected.size());
      $display("** lisp_token_scanner: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/lts_pkg.sv
design/lts_scan_core.sv
design/lts_rsp_queue.sv
design/lisp_token_scanner.sv
tb/sv/tb_top.sv
